### hdl/ofpu_pkg.sv
// Shared types, operand codes and capture codes of the optical-flow position update.
package ofpu_pkg;

    // Operand A sources (chunked by the hi flag where the value is wide)
    localparam logic [2:0] A_DROLL  = 3'd0;
    localparam logic [2:0] A_DPITCH = 3'd1;
    localparam logic [2:0] A_CX     = 3'd2;
    localparam logic [2:0] A_CY     = 3'd3;
    localparam logic [2:0] A_FX     = 3'd4;
    localparam logic [2:0] A_FY     = 3'd5;
    localparam logic [2:0] A_XC     = 3'd6;
    localparam logic [2:0] A_YC     = 3'd7;

    // Operand B sources
    localparam logic [2:0] B_R2P  = 3'd0;
    localparam logic [2:0] B_CONV = 3'd1;
    localparam logic [2:0] B_SUM  = 3'd2;
    localparam logic [2:0] B_YSIN = 3'd3;
    localparam logic [2:0] B_YCOS = 3'd4;

    // Accumulator start values
    localparam logic [2:0] I_DX  = 3'd0;
    localparam logic [2:0] I_DY  = 3'd1;
    localparam logic [2:0] I_R27 = 3'd2;
    localparam logic [2:0] I_R4  = 3'd3;
    localparam logic [2:0] I_R17 = 3'd4;

    // Accumulator capture targets
    localparam logic [3:0] CAP_NONE = 4'd0;
    localparam logic [3:0] CAP_CX   = 4'd1;
    localparam logic [3:0] CAP_CY   = 4'd2;
    localparam logic [3:0] CAP_FX   = 4'd3;
    localparam logic [3:0] CAP_FY   = 4'd4;
    localparam logic [3:0] CAP_XC   = 4'd5;
    localparam logic [3:0] CAP_YC   = 4'd6;
    localparam logic [3:0] CAP_LON  = 4'd7;
    localparam logic [3:0] CAP_LAT  = 4'd8;

    localparam int A_W     = 24;
    localparam int B_W     = 26;
    localparam int ACC_W   = 64;
    localparam int CHUNK_W = 23;

    localparam logic [4:0] LAST_STEP = 5'd18;

    typedef struct packed {
        logic en;
        logic clear;
        logic hi;
        logic neg;
    } mac_op_t;

    typedef struct packed {
        mac_op_t    op;
        logic [2:0] init_sel;
        logic [2:0] a_sel;
        logic [2:0] b_sel;
        logic [3:0] cap;
        logic       running;
        logic       done;
    } seq_out_t;

endpackage

### hdl/ofpu_mac.sv
// Shared signed multiply-accumulate unit with chunk shift and start-value load.
module ofpu_mac
    import ofpu_pkg::*;
(
    input  logic                    aclk,
    input  mac_op_t                 op,
    input  logic signed [A_W-1:0]   a,
    input  logic signed [B_W-1:0]   b,
    input  logic signed [ACC_W-1:0] init,
    output logic signed [ACC_W-1:0] acc
);

    logic signed [A_W+B_W-1:0] prod;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   term;
    logic signed [ACC_W-1:0]   base;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;

    assign prod     = a * b;
    assign prod_ext = {{(ACC_W-A_W-B_W){prod[A_W+B_W-1]}}, prod};
    // high chunk of A carries weight 2^23
    assign term     = op.hi ? {prod_ext[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} : prod_ext;
    assign base     = op.clear ? init : acc_reg;
    assign acc_next = op.neg ? (base - term) : (base + term);

    always_ff @(posedge aclk) begin
        if (op.en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

### hdl/ofpu_seq.sv
// Step sequencer driving the shared multiply-accumulate unit.
module ofpu_seq
    import ofpu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     start,
    output seq_out_t seq
);

    logic       running_reg, running_next;
    logic [4:0] step_reg, step_next;
    logic [3:0] cap_reg, cap_next;
    mac_op_t    op;
    logic [2:0] init_sel, a_sel, b_sel;
    logic [3:0] dst;

    always_comb begin
        op       = '0;
        init_sel = I_R27;
        a_sel    = A_CX;
        b_sel    = B_CONV;
        dst      = CAP_NONE;
        case (step_reg)
            5'd0: begin
                op = '{en: 1'b1, clear: 1'b1, hi: 1'b0, neg: 1'b1};
                init_sel = I_DX;  a_sel = A_DROLL;  b_sel = B_R2P;  dst = CAP_CX;
            end
            5'd1: begin
                op = '{en: 1'b1, clear: 1'b1, hi: 1'b0, neg: 1'b0};
                init_sel = I_DY;  a_sel = A_DPITCH; b_sel = B_R2P;  dst = CAP_CY;
            end
            5'd2: begin
                op = '{en: 1'b1, clear: 1'b1, hi: 1'b0, neg: 1'b0};
                init_sel = I_R27; a_sel = A_CX;     b_sel = B_CONV;
            end
            5'd3: begin
                op = '{en: 1'b1, clear: 1'b0, hi: 1'b1, neg: 1'b0};
                a_sel = A_CX; b_sel = B_CONV; dst = CAP_FX;
            end
            5'd4: begin
                op = '{en: 1'b1, clear: 1'b1, hi: 1'b0, neg: 1'b0};
                init_sel = I_R27; a_sel = A_CY;     b_sel = B_CONV;
            end
            5'd5: begin
                op = '{en: 1'b1, clear: 1'b0, hi: 1'b1, neg: 1'b0};
                a_sel = A_CY; b_sel = B_CONV; dst = CAP_FY;
            end
            5'd6: begin
                op = '{en: 1'b1, clear: 1'b1, hi: 1'b0, neg: 1'b1};
                init_sel = I_R4;  a_sel = A_FX;     b_sel = B_SUM;
            end
            5'd7: begin
                op = '{en: 1'b1, clear: 1'b0, hi: 1'b1, neg: 1'b1};
                a_sel = A_FX; b_sel = B_SUM; dst = CAP_XC;
            end
            5'd8: begin
                op = '{en: 1'b1, clear: 1'b1, hi: 1'b0, neg: 1'b1};
                init_sel = I_R4;  a_sel = A_FY;     b_sel = B_SUM;
            end
            5'd9: begin
                op = '{en: 1'b1, clear: 1'b0, hi: 1'b1, neg: 1'b1};
                a_sel = A_FY; b_sel = B_SUM; dst = CAP_YC;
            end
            5'd10: begin
                op = '{en: 1'b1, clear: 1'b1, hi: 1'b0, neg: 1'b0};
                init_sel = I_R17; a_sel = A_XC;     b_sel = B_YSIN;
            end
            5'd11: begin
                op = '{en: 1'b1, clear: 1'b0, hi: 1'b1, neg: 1'b0};
                a_sel = A_XC; b_sel = B_YSIN;
            end
            5'd12: begin
                op = '{en: 1'b1, clear: 1'b0, hi: 1'b0, neg: 1'b0};
                a_sel = A_YC; b_sel = B_YCOS;
            end
            5'd13: begin
                op = '{en: 1'b1, clear: 1'b0, hi: 1'b1, neg: 1'b0};
                a_sel = A_YC; b_sel = B_YCOS; dst = CAP_LON;
            end
            5'd14: begin
                op = '{en: 1'b1, clear: 1'b1, hi: 1'b0, neg: 1'b0};
                init_sel = I_R17; a_sel = A_YC;     b_sel = B_YSIN;
            end
            5'd15: begin
                op = '{en: 1'b1, clear: 1'b0, hi: 1'b1, neg: 1'b0};
                a_sel = A_YC; b_sel = B_YSIN;
            end
            5'd16: begin
                op = '{en: 1'b1, clear: 1'b0, hi: 1'b0, neg: 1'b1};
                a_sel = A_XC; b_sel = B_YCOS;
            end
            5'd17: begin
                op = '{en: 1'b1, clear: 1'b0, hi: 1'b1, neg: 1'b1};
                a_sel = A_XC; b_sel = B_YCOS; dst = CAP_LAT;
            end
            default: begin
                op = '0;
            end
        endcase
        if (!running_reg) begin
            op  = '0;
            dst = CAP_NONE;
        end
    end

    always_comb begin
        running_next = running_reg;
        step_next    = step_reg;
        cap_next     = dst;
        if (start) begin
            running_next = 1'b1;
            step_next    = '0;
        end else if (running_reg) begin
            if (step_reg == LAST_STEP) begin
                running_next = 1'b0;
            end else begin
                step_next = step_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            step_reg    <= '0;
            cap_reg     <= CAP_NONE;
        end else begin
            running_reg <= running_next;
            step_reg    <= step_next;
            cap_reg     <= cap_next;
        end
    end

    assign seq.op       = op;
    assign seq.init_sel = init_sel;
    assign seq.a_sel    = a_sel;
    assign seq.b_sel    = b_sel;
    assign seq.cap      = cap_reg;
    assign seq.running  = running_reg;
    assign seq.done     = running_reg && (step_reg == LAST_STEP);

endmodule

### hdl/optical_flow_position_update_top.sv
// Top level of the optical-flow position update: handshakes, registers, operand muxing.
//
//  channel  | direction | transfer when          | content
//  ---------+-----------+------------------------+------------------------------------
//  s_*      | in        | s_tvalid && s_tready   | one flow sample (tdata, 104 bits)
//  m_*      | out       | m_tvalid && m_tready   | lon/lat movement (tdata), updated (tuser)
//  cfg_*    | in        | cfg_wr_en              | register write, index 0..3
//
//  An item whose gate passes runs through the shared multiply-accumulate unit
//  (18 multiply steps plus a final capture step), then loads the output register.
//  A gated-off item goes straight to the output register.
//  s_tready is high only while idle; a result waiting in the output register does not
//  block the next transfer in, only the hand-over of the following result.
//  Reset is synchronous, active low; it clears control and stored history and sets the registers to their reset values.
module optical_flow_position_update_top
    import ofpu_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [7:0] delta_x, [15:8] delta_y, [23:16] quality, [39:24] roll_angle,
    // [55:40] pitch_angle, [71:56] yaw_cosine, [87:72] yaw_sine, [103:88] height
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] move_lon, [63:32] move_lat
    output logic [63:0]  m_tdata,
    // [0] updated
    output logic         m_tuser,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_wdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [1:0] REG_MIN_QUALITY = 2'd0;
    localparam logic [1:0] REG_MAX_TILT    = 2'd1;
    localparam logic [1:0] REG_R2P         = 2'd2;
    localparam logic [1:0] REG_CONV        = 2'd3;

    // input fields
    logic signed [7:0]  in_dx, in_dy;
    logic [7:0]         in_quality;
    logic signed [15:0] in_roll, in_pitch, in_ycos, in_ysin;
    logic [15:0]        in_height;

    assign in_dx      = s_tdata[7:0];
    assign in_dy      = s_tdata[15:8];
    assign in_quality = s_tdata[23:16];
    assign in_roll    = s_tdata[39:24];
    assign in_pitch   = s_tdata[55:40];
    assign in_ycos    = s_tdata[71:56];
    assign in_ysin    = s_tdata[87:72];
    assign in_height  = s_tdata[103:88];

    // configuration
    logic [7:0]  min_quality_reg;
    logic [14:0] max_tilt_reg;
    logic [15:0] r2p_reg;
    logic [23:0] conv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_quality_reg <= 8'd10;
            max_tilt_reg    <= 15'd3217;
            r2p_reg         <= 16'd41725;
            conv_reg        <= 24'd103180;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MIN_QUALITY: min_quality_reg <= cfg_wdata[7:0];
                REG_MAX_TILT:    max_tilt_reg    <= cfg_wdata[14:0];
                REG_R2P:         r2p_reg         <= cfg_wdata[15:0];
                REG_CONV:        conv_reg        <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // control
    logic [1:0] state_reg, state_next;
    logic       s_xfer, out_load, gate_ok;
    logic       upd_reg;
    logic       m_tvalid_reg;
    seq_out_t   seq;

    // stored history and sample latches
    logic signed [15:0] prev_roll_reg, prev_pitch_reg;
    logic [15:0]        prev_height_reg;
    logic signed [31:0] held_lon_reg, held_lat_reg;
    logic signed [16:0] droll_reg, dpitch_reg;
    logic [16:0]        hsum_reg;
    logic signed [7:0]  dx_reg, dy_reg;
    logic signed [15:0] ycos_reg, ysin_reg;

    // intermediates
    logic signed [34:0] cx_reg, cy_reg;
    logic signed [31:0] fx_reg, fy_reg;
    logic signed [43:0] xc_reg, yc_reg;

    logic [16:0] abs_roll, abs_pitch;

    assign abs_roll  = in_roll[15]  ? (17'd0 - {in_roll[15], in_roll})   : {1'b0, in_roll};
    assign abs_pitch = in_pitch[15] ? (17'd0 - {in_pitch[15], in_pitch}) : {1'b0, in_pitch};
    assign gate_ok   = (in_quality >= min_quality_reg)
                    && (abs_roll  <= {2'b00, max_tilt_reg})
                    && (abs_pitch <= {2'b00, max_tilt_reg});

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_xfer) state_next = gate_ok ? ST_RUN : ST_DONE;
            ST_RUN:  if (seq.done) state_next = ST_DONE;
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            upd_reg         <= 1'b0;
            prev_roll_reg   <= '0;
            prev_pitch_reg  <= '0;
            prev_height_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (s_xfer) begin
                upd_reg         <= gate_ok;
                prev_roll_reg   <= in_roll;
                prev_pitch_reg  <= in_pitch;
                prev_height_reg <= in_height;
            end
        end
    end

    // sample latch: deltas against the previous sample, altitude sum
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            droll_reg  <= 17'(in_roll)  - 17'(prev_roll_reg);
            dpitch_reg <= 17'(in_pitch) - 17'(prev_pitch_reg);
            hsum_reg   <= {1'b0, in_height} + {1'b0, prev_height_reg};
            dx_reg     <= in_dx;
            dy_reg     <= in_dy;
            ycos_reg   <= in_ycos;
            ysin_reg   <= in_ysin;
        end
    end

    // operand selection for the shared unit
    logic signed [A_W-1:0]   mac_a;
    logic signed [B_W-1:0]   mac_b;
    logic signed [ACC_W-1:0] mac_init;
    logic signed [ACC_W-1:0] acc;

    always_comb begin
        case (seq.a_sel)
            A_DROLL:  mac_a = {{(A_W-17){droll_reg[16]}}, droll_reg};
            A_DPITCH: mac_a = {{(A_W-17){dpitch_reg[16]}}, dpitch_reg};
            A_CX: mac_a = seq.op.hi ? {{(A_W-12){cx_reg[34]}}, cx_reg[34:23]}
                                    : {1'b0, cx_reg[22:0]};
            A_CY: mac_a = seq.op.hi ? {{(A_W-12){cy_reg[34]}}, cy_reg[34:23]}
                                    : {1'b0, cy_reg[22:0]};
            A_FX: mac_a = seq.op.hi ? {{(A_W-9){fx_reg[31]}}, fx_reg[31:23]}
                                    : {1'b0, fx_reg[22:0]};
            A_FY: mac_a = seq.op.hi ? {{(A_W-9){fy_reg[31]}}, fy_reg[31:23]}
                                    : {1'b0, fy_reg[22:0]};
            A_XC: mac_a = seq.op.hi ? {{(A_W-21){xc_reg[43]}}, xc_reg[43:23]}
                                    : {1'b0, xc_reg[22:0]};
            A_YC: mac_a = seq.op.hi ? {{(A_W-21){yc_reg[43]}}, yc_reg[43:23]}
                                    : {1'b0, yc_reg[22:0]};
            default: mac_a = '0;
        endcase
    end

    always_comb begin
        case (seq.b_sel)
            B_R2P:  mac_b = {{(B_W-16){1'b0}}, r2p_reg};
            B_CONV: mac_b = {{(B_W-24){1'b0}}, conv_reg};
            B_SUM:  mac_b = {{(B_W-17){1'b0}}, hsum_reg};
            B_YSIN: mac_b = {{(B_W-16){ysin_reg[15]}}, ysin_reg};
            B_YCOS: mac_b = {{(B_W-16){ycos_reg[15]}}, ycos_reg};
            default: mac_b = '0;
        endcase
    end

    // start values also carry the round-half-up offsets of the later shifts
    always_comb begin
        case (seq.init_sel)
            I_DX:  mac_init = {{(ACC_W-28){dx_reg[7]}}, dx_reg, 20'd0};
            I_DY:  mac_init = {{(ACC_W-28){dy_reg[7]}}, dy_reg, 20'd0};
            I_R27: mac_init = 64'h0000_0000_0800_0000;
            I_R4:  mac_init = 64'h0000_0000_0000_0010;
            I_R17: mac_init = 64'h0000_0000_0002_0000;
            default: mac_init = '0;
        endcase
    end

    ofpu_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_xfer && gate_ok),
        .seq     (seq)
    );

    ofpu_mac u_mac (
        .aclk (aclk),
        .op   (seq.op),
        .a    (mac_a),
        .b    (mac_b),
        .init (mac_init),
        .acc  (acc)
    );

    // Q.8 result with saturation to 32 bits
    logic        fits32;
    logic [31:0] sat_val;

    assign fits32  = (acc[63:49] == {15{acc[49]}});
    assign sat_val = fits32 ? acc[49:18] : (acc[63] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    always_ff @(posedge aclk) begin
        case (seq.cap)
            CAP_CX: cx_reg <= acc[34:0];
            CAP_CY: cy_reg <= acc[34:0];
            CAP_FX: fx_reg <= acc[59:28];
            CAP_FY: fy_reg <= acc[59:28];
            CAP_XC: xc_reg <= acc[48:5];
            CAP_YC: yc_reg <= acc[48:5];
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_lon_reg <= '0;
            held_lat_reg <= '0;
        end else begin
            if (seq.cap == CAP_LON) held_lon_reg <= sat_val;
            if (seq.cap == CAP_LAT) held_lat_reg <= sat_val;
        end
    end

    // output register
    logic [63:0] m_tdata_reg;
    logic        m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {held_lat_reg, held_lon_reg};
            m_tuser_reg <= upd_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // sequencer only runs while the control is in its compute state
    a_seq_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        seq.running |-> (state_reg == ST_RUN))
        else $error("sequencer running outside compute state");

    // a gated-off sample skips the compute and holds movement
    a_gate_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && !gate_ok) |=> (state_reg == ST_DONE) && !upd_reg && !seq.running)
        else $error("gated-off sample entered compute");

    // held movement only changes through the lon/lat captures
    a_held_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq.cap != CAP_LON) && (seq.cap != CAP_LAT)
        |=> $stable(held_lon_reg) && $stable(held_lat_reg))
        else $error("held movement changed outside capture");

    // loaded result matches held movement
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid && (m_tdata == {held_lat_reg, held_lon_reg}))
        else $error("output register does not match held movement");

endmodule

### tb/ofpu_tb_pkg.sv
// Register indexes and reset values shared by the flow update testbench files.
`timescale 1ns / 1ps
package ofpu_tb_pkg;

    localparam logic [1:0] REG_MIN_QUALITY = 2'd0;
    localparam logic [1:0] REG_MAX_TILT    = 2'd1;
    localparam logic [1:0] REG_RAD_TO_PIX  = 2'd2;
    localparam logic [1:0] REG_CONV_FACTOR = 2'd3;

    localparam int MIN_QUALITY_RST = 10;
    localparam int MAX_TILT_RST    = 3217;
    localparam int RAD_TO_PIX_RST  = 41725;
    localparam int CONV_FACTOR_RST = 103180;

endpackage

### tb/ofpu_flow_checker.sv
// Monitor that predicts lon/lat movement per flow sample and compares it with the block.
`timescale 1ns / 1ps
module ofpu_flow_checker
    import ofpu_tb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [103:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic         m_tuser,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_wdata,
    output int           mismatches,
    output int           outstanding
);

    localparam int MAX_REPORTS = 200;

    typedef struct packed {
        logic        [15:0] height;
        logic signed [15:0] yaw_sine;
        logic signed [15:0] yaw_cosine;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic        [7:0]  quality;
        logic signed [7:0]  delta_y;
        logic signed [7:0]  delta_x;
    } flow_sample_t;

    typedef struct {
        logic signed [31:0] lon;
        logic signed [31:0] lat;
        logic               updated;
    } move_t;

    logic [7:0]  min_quality_q;
    logic [14:0] max_tilt_q;
    logic [15:0] rad_to_pix_q;
    logic [23:0] conv_factor_q;

    logic signed [15:0] prior_roll;
    logic signed [15:0] prior_pitch;
    logic        [15:0] prior_height;
    logic signed [31:0] hold_lon;
    logic signed [31:0] hold_lat;

    move_t expected_moves[$];
    int    error_count = 0;

    assign mismatches = error_count;

    // divide by 2^sh, ties go up
    function automatic longint half_up_shift(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > longint'(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        if (v < -longint'(32'sh7FFF_FFFF) - 1)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic move_t track_position(flow_sample_t smp);
        move_t  res;
        int     abs_roll;
        int     abs_pitch;
        logic   pass;
        longint roll_px;
        longint pitch_px;
        longint cx;
        longint cy;
        longint fx;
        longint fy;
        longint hsum;
        longint xc;
        longint yc;
        abs_roll  = int'(smp.roll);
        abs_pitch = int'(smp.pitch);
        if (abs_roll < 0)
            abs_roll = -abs_roll;
        if (abs_pitch < 0)
            abs_pitch = -abs_pitch;
        pass = (smp.quality >= min_quality_q) && (abs_roll <= int'(max_tilt_q))
               && (abs_pitch <= int'(max_tilt_q));
        if (pass) begin
            // pixel motion caused by the attitude change, Q.20
            roll_px  = longint'(int'(smp.roll) - int'(prior_roll)) * longint'(rad_to_pix_q);
            pitch_px = -longint'(int'(smp.pitch) - int'(prior_pitch)) * longint'(rad_to_pix_q);
            cx   = (longint'(smp.delta_x) <<< 20) - roll_px;
            cy   = (longint'(smp.delta_y) <<< 20) - pitch_px;
            fx   = half_up_shift(cx * longint'(conv_factor_q), 28);
            fy   = half_up_shift(cy * longint'(conv_factor_q), 28);
            hsum = longint'(smp.height) + longint'(prior_height);
            xc   = half_up_shift(-fx * hsum, 5);
            yc   = half_up_shift(-fy * hsum, 5);
            hold_lon = clamp32(half_up_shift(xc * longint'(smp.yaw_sine)
                                             + yc * longint'(smp.yaw_cosine), 18));
            hold_lat = clamp32(half_up_shift(yc * longint'(smp.yaw_sine)
                                             - xc * longint'(smp.yaw_cosine), 18));
        end
        prior_roll   = smp.roll;
        prior_pitch  = smp.pitch;
        prior_height = smp.height;
        res.lon      = hold_lon;
        res.lat      = hold_lat;
        res.updated  = pass;
        return res;
    endfunction

    always @(posedge aclk) begin : monitor
        move_t got;
        move_t want;
        if (!aresetn) begin
            min_quality_q = MIN_QUALITY_RST;
            max_tilt_q    = MAX_TILT_RST;
            rad_to_pix_q  = RAD_TO_PIX_RST;
            conv_factor_q = CONV_FACTOR_RST;
            prior_roll    = '0;
            prior_pitch   = '0;
            prior_height  = '0;
            hold_lon      = '0;
            hold_lat      = '0;
            expected_moves.delete();
        end else begin
            // results first: a result leaving now belongs to an earlier sample
            if (m_tvalid && m_tready) begin
                got.lon     = m_tdata[31:0];
                got.lat     = m_tdata[63:32];
                got.updated = m_tuser;
                if (expected_moves.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $error("result transfer with no sample outstanding");
                end else begin
                    want = expected_moves.pop_front();
                    if (got.lon !== want.lon) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $error("move_lon: expected %0d, got %0d", want.lon, got.lon);
                    end
                    if (got.lat !== want.lat) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $error("move_lat: expected %0d, got %0d", want.lat, got.lat);
                    end
                    if (got.updated !== want.updated) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $error("updated: expected %0d, got %0d",
                                   want.updated, got.updated);
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MIN_QUALITY: min_quality_q = cfg_wdata[7:0];
                    REG_MAX_TILT:    max_tilt_q    = cfg_wdata[14:0];
                    REG_RAD_TO_PIX:  rad_to_pix_q  = cfg_wdata[15:0];
                    REG_CONV_FACTOR: conv_factor_q = cfg_wdata[23:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_moves.push_back(track_position(flow_sample_t'(s_tdata)));
        end
        outstanding <= expected_moves.size();
    end

endmodule

### tb/optical_flow_position_update_top_tb.sv
// Stimulus and verdict for the optical-flow position update block.
`timescale 1ns / 1ps
module optical_flow_position_update_top_tb;
    import ofpu_tb_pkg::*;

    logic         aclk;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [63:0]  m_tdata;
    logic         m_tuser;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_index = REG_MIN_QUALITY;
    logic [23:0]  cfg_wdata = '0;

    int   mismatches;
    int   outstanding;

    // when set, neither side idles
    logic steady = 1'b0;

    // gate limits as last written; used to steer samples toward or past the gate
    int   cur_min_quality = MIN_QUALITY_RST;
    int   cur_max_tilt    = MAX_TILT_RST;

    optical_flow_position_update_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ofpu_flow_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Receiver: back-pressure in about a third of the cycles unless steady
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= steady || ($urandom_range(99) >= 34);
    end

    // Generous cap; a correct run ends far earlier.
    initial begin
        #5_000_000;
        $display("optical_flow_position_update_top_tb failed");
        $finish;
    end

    // One flow sample on the input channel. Random idle cycles go before it unless steady,
    // tvalid stays up across back-to-back transfers.
    task automatic send_sample(input int dx, input int dy, input int qual, input int roll,
                               input int pitch, input int ycos, input int ysin, input int hgt);
        while (!steady && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hgt[15:0], ysin[15:0], ycos[15:0], pitch[15:0], roll[15:0],
                     qual[7:0], dy[7:0], dx[7:0]};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending and wait until every result has been handed over.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Register write; junk above the register width must be dropped by the block.
    task automatic put_reg(input logic [1:0] idx, input int val, input int width);
        logic [31:0] word;
        word = ($urandom << width) | val;
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= word[23:0];
        @(posedge aclk);
    endtask

    // Only called with the block idle (after reset or after a drain).
    task automatic set_config(input int minq, input int tilt, input int r2p, input int conv);
        put_reg(REG_MIN_QUALITY, minq, 8);
        put_reg(REG_MAX_TILT, tilt, 15);
        put_reg(REG_RAD_TO_PIX, r2p, 16);
        put_reg(REG_CONV_FACTOR, conv, 24);
        cfg_wr_en <= 1'b0;
        cur_min_quality = minq;
        cur_max_tilt    = tilt;
    endtask

    // Mostly samples that pass the gate, so the movement math gets exercised;
    // the rest fail on quality, on tilt, or are raw noise.
    task automatic send_random_sample();
        int kind;
        int qual;
        int roll;
        int pitch;
        int mag;
        int swap;
        int ycos;
        int ysin;
        int hgt;
        kind  = $urandom_range(99);
        qual  = $urandom_range(255);
        roll  = $urandom_range(65535);
        pitch = $urandom_range(65535);
        if (kind < 80) begin
            roll  = int'($urandom_range(2 * cur_max_tilt)) - cur_max_tilt;
            pitch = int'($urandom_range(2 * cur_max_tilt)) - cur_max_tilt;
            if (kind < 70)
                qual = $urandom_range(255, cur_min_quality);
            else if (cur_min_quality > 0)
                qual = $urandom_range(cur_min_quality - 1);
        end else if (kind < 92) begin
            // just past the tilt bound up to the most negative angle
            qual  = $urandom_range(255, cur_min_quality);
            mag   = $urandom_range(32768, cur_max_tilt + 1);
            roll  = ($urandom_range(1) == 1 || mag > 32767) ? -mag : mag;
            pitch = int'($urandom_range(2 * cur_max_tilt)) - cur_max_tilt;
            if ($urandom_range(1) == 1) begin
                swap  = roll;
                roll  = pitch;
                pitch = swap;
            end
        end
        if ($urandom_range(99) < 80) begin
            ycos = int'($urandom_range(32768)) - 16384;
            ysin = int'($urandom_range(32768)) - 16384;
        end else begin
            // yaw terms outside the unit range are used as given
            ycos = $urandom_range(65535);
            ysin = $urandom_range(65535);
        end
        hgt = ($urandom_range(3) == 0) ? $urandom_range(300) : $urandom_range(65535);
        send_sample($urandom_range(255), $urandom_range(255), qual, roll, pitch,
                    ycos, ysin, hgt);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: ;    // reset values
                1: set_config(0, 32767, 65535, 24'hFF_FFFF);
                2: set_config(255, 0, 0, 0);
                default: set_config($urandom_range(3) == 0 ? $urandom_range(255)
                                                           : $urandom_range(40),
                                    $urandom_range(32767), $urandom_range(65535),
                                    $urandom_range(24'hFF_FFFF));
            endcase
            if (phase == 5)
                steady <= 1'b1;
            else if (phase == 6)
                steady <= 1'b0;

            if (phase == 0) begin
                // quality right at the bound, then the delta and tilt extremes
                send_sample(0, 0, 10, 0, 0, 16384, 0, 100);
                send_sample(127, -128, 255, 3217, -3217, 0, 16384, 65535);
                send_sample(-128, 127, 10, -3217, 3217, -16384, -16384, 65535);
                // gated off: low quality, roll and pitch just past the bound,
                // most negative angles, zero quality
                send_sample(5, -5, 9, 0, 0, 16384, 0, 500);
                send_sample(5, -5, 200, 3218, 0, 16384, 0, 500);
                send_sample(5, -5, 200, 0, -3218, 16384, 0, 500);
                send_sample(1, 1, 255, -32768, 0, 16384, 0, 500);
                send_sample(1, 1, 255, 0, -32768, 16384, 0, 500);
                send_sample(1, 1, 0, 32767, 32767, 16384, 0, 500);
                // yaw terms out of range
                send_sample(-1, 2, 100, 100, -100, 32767, -32768, 1000);
                // zero altitude twice running
                send_sample(50, -50, 100, 0, 0, 11585, 11585, 0);
                send_sample(50, -50, 100, 0, 0, 11585, -11585, 0);
                send_sample(-20, 30, 100, -1500, 2000, -16384, 0, 40000);
            end else if (phase == 1) begin
                // full-scale swings with maximum gains: both saturation limits
                send_sample(127, -128, 0, 32767, -32767, 16384, 16384, 65535);
                send_sample(-128, 127, 0, -32767, 32767, -16384, 16384, 65535);
                send_sample(127, 127, 0, -32767, -32767, 32767, -32768, 65535);
                // only the most negative angle fails at the widest tilt limit
                send_sample(0, 0, 0, -32768, 0, 0, 0, 0);
            end

            repeat (230) begin
                send_random_sample();
                if ($urandom_range(99) == 0)
                    drain();
            end
            drain();
        end

        repeat (30) @(posedge aclk);
        if (mismatches == 0)
            $display("optical_flow_position_update_top_tb passed");
        else
            $display("optical_flow_position_update_top_tb failed");
        $finish;
    end

endmodule

### filelist.f
hdl/ofpu_pkg.sv
hdl/ofpu_mac.sv
hdl/ofpu_seq.sv
hdl/optical_flow_position_update_top.sv
tb/ofpu_tb_pkg.sv
tb/ofpu_flow_checker.sv
tb/optical_flow_position_update_top_tb.sv
